### rtl/checked_int32_alu_macros.svh
// ----------------------------------------------------------------------------
// checked_int32_alu_macros
// Assertion macros for the checked 32-bit ALU.
// ----------------------------------------------------------------------------
`ifndef CHECKED_INT32_ALU_MACROS_SVH
`define CHECKED_INT32_ALU_MACROS_SVH
`ifndef SYNTHESIS
`define CIA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CIA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CIA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/cia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types and codes of the checked 32-bit ALU.
// ----------------------------------------------------------------------------
package cia_pkg;
    localparam int DataWidth = 32;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        FAULT_NONE    = 3'd0,
        FAULT_HIGH    = 3'd1,
        FAULT_LOW     = 3'd2,
        FAULT_RANGE   = 3'd3,
        FAULT_DIVZERO = 3'd4
    } fault_t;
endpackage

### rtl/cia_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_divider
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Carries a side result and the valid bit along so other operations share it.
// ----------------------------------------------------------------------------
module cia_divider
    import cia_pkg::*;
#(
    parameter int W = DataWidth
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    input  logic         neg_q,
    input  logic         use_div,
    input  logic [W-1:0] side_value,
    input  logic [2:0]   side_fault,
    output logic         out_valid,
    output logic [W-1:0] out_value,
    output logic [2:0]   out_fault
);
    logic         valid_reg [1:W];
    logic [W-1:0] rem_reg   [1:W];
    logic [W-1:0] quo_reg   [1:W];
    logic [W-1:0] dsr_reg   [1:W];
    logic         neg_reg   [1:W];
    logic         use_reg   [1:W];
    logic [W-1:0] sval_reg  [1:W];
    logic [2:0]   sflt_reg  [1:W];

    for (genvar s = 0; s < W; s++) begin : g_stage
        logic         cur_valid;
        logic [W-1:0] cur_rem;
        logic [W-1:0] cur_quo;
        logic [W-1:0] cur_dsr;
        logic         cur_neg;
        logic         cur_use;
        logic [W-1:0] cur_sval;
        logic [2:0]   cur_sflt;
        logic [W:0]   trial;
        logic [W-1:0] rem_next;
        logic [W-1:0] quo_next;

        if (s == 0) begin : g_head
            assign cur_valid = in_valid;
            assign cur_rem   = '0;
            assign cur_quo   = dividend;
            assign cur_dsr   = divisor;
            assign cur_neg   = neg_q;
            assign cur_use   = use_div;
            assign cur_sval  = side_value;
            assign cur_sflt  = side_fault;
        end
        else begin : g_body
            assign cur_valid = valid_reg[s];
            assign cur_rem   = rem_reg[s];
            assign cur_quo   = quo_reg[s];
            assign cur_dsr   = dsr_reg[s];
            assign cur_neg   = neg_reg[s];
            assign cur_use   = use_reg[s];
            assign cur_sval  = sval_reg[s];
            assign cur_sflt  = sflt_reg[s];
        end

        always_comb
        begin
            trial = {cur_rem, cur_quo[W-1]} - {1'b0, cur_dsr};
            if (trial[W])
            begin
                rem_next = {cur_rem[W-2:0], cur_quo[W-1]};
                quo_next = {cur_quo[W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {cur_quo[W-2:0], 1'b1};
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s+1] <= 1'b0;
            else if (en)
                valid_reg[s+1] <= cur_valid;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= rem_next;
                quo_reg[s+1]  <= quo_next;
                dsr_reg[s+1]  <= cur_dsr;
                neg_reg[s+1]  <= cur_neg;
                use_reg[s+1]  <= cur_use;
                sval_reg[s+1] <= cur_sval;
                sflt_reg[s+1] <= cur_sflt;
            end
        end
    end

    assign out_valid = valid_reg[W];
    assign out_fault = sflt_reg[W];
    assign out_value = !use_reg[W] ? sval_reg[W]
                     : (neg_reg[W] ? (W)'(-quo_reg[W]) : quo_reg[W]);
endmodule

### rtl/checked_int32_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_int32_alu
// Signed 32-bit add, subtract, multiply and divide with fault codes.
// ----------------------------------------------------------------------------
// Items enter on in_valid/in_ready with func, lhs and rhs; one result per
// item leaves on out_valid/out_ready with value and fault. The user must
// write safe_value on cfg_valid/cfg_ready only while the unit is idle;
// the block does not enforce it. It is taken with each item at entry.
// The pipe has one input stage, one stage for the operand decode and the
// multiply, 32 divider stages (one quotient bit each), and the output
// register. Every operation rides the same pipe, so results stay in order
// and one item can enter each cycle while the receiver is not stalling.
// When the receiver stalls with a result waiting, the whole pipe holds and
// in_ready drops; nothing is lost or repeated. Reset empties the pipe and
// sets safe_value to 0.
// ----------------------------------------------------------------------------
`include "checked_int32_alu_macros.svh"
module checked_int32_alu
    import cia_pkg::*;
#(
    parameter int W = DataWidth
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   func,
    input  logic [W-1:0] lhs,
    input  logic [W-1:0] rhs,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] value,
    output logic [2:0]   fault,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [W-1:0] cfg_data
);
    logic         en;
    logic [W-1:0] safe_reg;
    logic         v1_reg;
    logic [1:0]   f1_reg;
    logic [W-1:0] a1_reg, b1_reg, s1_reg;
    logic         v2_reg;
    logic [W-1:0] dvd2_reg, dsr2_reg, sval2_reg;
    logic         neg2_reg, use2_reg;
    logic [2:0]   sflt2_reg;
    logic         dv_valid;
    logic [W-1:0] dv_value;
    logic [2:0]   dv_fault;
    logic         out_valid_reg;
    logic [W-1:0] value_reg;
    logic [2:0]   fault_reg;
    logic         out_stall;
    logic         zero_fault;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign fault     = fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            safe_reg <= '0;
        else if (cfg_valid)
            safe_reg <= cfg_data;
    end

    // Stage 1: register the operands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg <= func;
            a1_reg <= lhs;
            b1_reg <= rhs;
            s1_reg <= safe_reg;
        end
    end

    // Stage 2: add/sub checks, multiply, divide setup.
    logic [W:0]     sum;
    logic [2*W-1:0] prod;
    logic [W-1:0]   sval_next, dvd_next, dsr_next;
    logic [2:0]     sflt_next;
    logic           use_next, neg_next;
    always_comb
    begin
        sum       = '0;
        prod      = (2*W)'(signed'(a1_reg)) * (2*W)'(signed'(b1_reg));
        sval_next = '0;
        sflt_next = FAULT_NONE;
        use_next  = 1'b0;
        neg_next  = a1_reg[W-1] ^ b1_reg[W-1];
        dvd_next  = a1_reg[W-1] ? (W)'(-a1_reg) : a1_reg;
        dsr_next  = b1_reg[W-1] ? (W)'(-b1_reg) : b1_reg;
        case (func_t'(f1_reg))
            FUNC_ADD, FUNC_SUB:
            begin
                if (func_t'(f1_reg) == FUNC_ADD)
                    sum = {a1_reg[W-1], a1_reg} + {b1_reg[W-1], b1_reg};
                else
                    sum = {a1_reg[W-1], a1_reg} - {b1_reg[W-1], b1_reg};
                if (sum[W] != sum[W-1])
                begin
                    sval_next = s1_reg;
                    sflt_next = sum[W] ? FAULT_LOW : FAULT_HIGH;
                end
                else
                    sval_next = sum[W-1:0];
            end
            FUNC_MUL:
            begin
                if (prod[2*W-1:W-1] != {(W+1){prod[W-1]}})
                    sflt_next = FAULT_RANGE;
                else
                    sval_next = prod[W-1:0];
            end
            FUNC_DIV:
            begin
                if (b1_reg == '0)
                    sflt_next = FAULT_DIVZERO;
                else if (a1_reg == {1'b1, {(W-1){1'b0}}} && b1_reg == '1)
                    sflt_next = FAULT_RANGE;
                else
                    use_next = 1'b1;
            end
            default:
                sflt_next = FAULT_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd2_reg  <= dvd_next;
            dsr2_reg  <= dsr_next;
            neg2_reg  <= neg_next;
            use2_reg  <= use_next;
            sval2_reg <= sval_next;
            sflt2_reg <= sflt_next;
        end
    end

    cia_divider #(.W(W)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (v2_reg),
        .dividend   (dvd2_reg),
        .divisor    (dsr2_reg),
        .neg_q      (neg2_reg),
        .use_div    (use2_reg),
        .side_value (sval2_reg),
        .side_fault (sflt2_reg),
        .out_valid  (dv_valid),
        .out_value  (dv_value),
        .out_fault  (dv_fault)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= dv_value;
            fault_reg <= dv_fault;
        end
    end

    assign out_stall  = out_valid && !out_ready;
    assign zero_fault = (fault == FAULT_RANGE) || (fault == FAULT_DIVZERO);

    `CIA_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)
    `CIA_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_stall, out_valid && $stable(value) && $stable(fault))
    `CIA_ASSERT_IMP(a_fault_code, clk, rst_n, out_valid, fault <= FAULT_DIVZERO)
    `CIA_ASSERT_IMP(a_zero_on_fault, clk, rst_n, out_valid && zero_fault, value == '0)
endmodule

### tb/tb_checked_int32_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checked_int32_alu
// Self-checking bench for the checked 32-bit ALU. Each accepted item is
// run through a local model of add, subtract, multiply and divide with
// their fault rules. Each result is compared with the oldest prediction.
// Directed corner operands come first, then random items under several
// substitute values, with random idling on both sides for all but the last.
// ----------------------------------------------------------------------------
module tb_checked_int32_alu
    import cia_pkg::*;
;
    typedef struct packed {
        logic [31:0] value;
        fault_t      fault;
    } alu_result_t;

    class alu_scoreboard;
        logic signed [31:0] substitute;
        alu_result_t        pending[$];
        int                 errors;

        function new();
            substitute = '0;
            pending = {};
            errors = 0;
        endfunction

        // Works out the result of one accepted item and queues it.
        function void note_item(func_t op, logic signed [31:0] a, logic signed [31:0] b);
            logic signed [63:0] exact;
            alu_result_t        r;
            exact = '0;
            r.value = '0;
            r.fault = FAULT_NONE;
            case (op)
                FUNC_ADD, FUNC_SUB:
                begin
                    if (op == FUNC_ADD)
                        exact = 64'(a) + 64'(b);
                    else
                        exact = 64'(a) - 64'(b);
                    if (exact > 64'sd2147483647)
                    begin
                        r.value = substitute;
                        r.fault = FAULT_HIGH;
                    end
                    else if (exact < -64'sd2147483648)
                    begin
                        r.value = substitute;
                        r.fault = FAULT_LOW;
                    end
                    else
                        r.value = exact[31:0];
                end
                FUNC_MUL:
                begin
                    exact = 64'(a) * 64'(b);
                    if (exact > 64'sd2147483647 || exact < -64'sd2147483648)
                        r.fault = FAULT_RANGE;
                    else
                        r.value = exact[31:0];
                end
                default:
                begin
                    if (b == 0)
                        r.fault = FAULT_DIVZERO;
                    else if (a == 32'sh80000000 && b == -32'sd1)
                        r.fault = FAULT_RANGE;
                    else
                        r.value = a / b;
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] v, logic [2:0] f);
            alu_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result value=%h fault=%0d", v, f);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (v !== e.value)
            begin
                $error("value: expected %h, actual %h", e.value, v);
                errors++;
            end
            if (f !== e.fault)
            begin
                $error("fault: expected %0d, actual %0d", e.fault, f);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] value;
    logic [2:0]  fault;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    alu_scoreboard board;
    bit            calm;

    checked_int32_alu dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .lhs(lhs), .rhs(rhs),
        .out_valid(out_valid), .out_ready(out_ready),
        .value(value), .fault(fault),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("checked_int32_alu: mismatch");
        $finish;
    end

    // Result side: random stall bursts, checked at each accepting edge.
    initial
    begin
        int stall;
        stall = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_result(value, fault);
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 10) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_substitute(logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        board.substitute = d;
        cfg_valid <= 1'b0;
    endtask

    // The valid line stays high from one item to the next; it drops only
    // for an idle burst or when the sender stops.
    task automatic send_item(func_t op, logic [31:0] a, logic [31:0] b);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= op;
        lhs <= a;
        rhs <= b;
        do @(posedge clk); while (!in_ready);
        board.note_item(op, a, b);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (board.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'hffffffff;
            3: return 32'(int'($urandom_range(0, 20)) - 10);
            4: return 32'($urandom_range(0, 65535)) - 32'd32768;
            5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [31:0] extremes[6];
        logic [31:0] settings[5];
        board = new();
        calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_ADD;
        lhs = '0;
        rhs = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: overflow both ways, multiply range, zero divisor and
        // the minimum divided by minus one, first under the reset substitute.
        send_item(FUNC_ADD, 32'h7fffffff, 32'd1);
        send_item(FUNC_ADD, 32'h80000000, 32'hffffffff);
        send_item(FUNC_SUB, 32'h80000000, 32'd1);
        send_item(FUNC_SUB, 32'h7fffffff, 32'hffffffff);
        send_item(FUNC_SUB, 32'h00000000, 32'h80000000);
        send_item(FUNC_MUL, 32'h00010000, 32'h00010000);
        send_item(FUNC_MUL, 32'h80000000, 32'hffffffff);
        send_item(FUNC_MUL, 32'h80000000, 32'd1);
        send_item(FUNC_MUL, 32'hffff0000, 32'h00008000);
        send_item(FUNC_DIV, 32'd7, 32'd0);
        send_item(FUNC_DIV, 32'h80000000, 32'hffffffff);
        send_item(FUNC_DIV, 32'hfffffff9, 32'd2);
        send_item(FUNC_DIV, 32'h80000000, 32'd1);
        send_item(FUNC_DIV, 32'h7fffffff, 32'h80000000);
        send_item(FUNC_ADD, 32'h7fffffff, 32'h80000000);
        drain();

        settings[0] = 32'h7fffffff;
        settings[1] = 32'h80000000;
        settings[2] = 32'hffffffff;
        settings[3] = 32'h5a5aa5a5;
        settings[4] = 32'h00000000;
        for (int s = 0; s < 5; s++)
        begin
            write_substitute(s == 3 ? $urandom : settings[s]);
            if (s == 4)
                calm = 1'b1;
            for (int i = 0; i < 330; i++)
                send_item(func_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("checked_int32_alu: match");
        else
            $display("checked_int32_alu: mismatch");
        $finish;
    end
endmodule
